>>> hw/rtl/cfpt_pkg.sv
package cfpt_pkg;

  // Input transaction: a received byte or a time tick
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
    logic [7:0] elapsed_ms;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [2:0]         report_kind;
    logic [1:0]         current_mode;
    logic               offline_flag;
    logic [7:0]         status_byte;
    logic [7:0]         flag_byte;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
    logic [7:0]         period_ms;
  } out_item_t;

  // Item kinds
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_TICK = 1'b1;

  // Frame header and type bytes
  localparam logic [7:0] HDR_SYNC0 = 8'hAA;
  localparam logic [7:0] HDR_SYNC1 = 8'h29;
  localparam logic [7:0] HDR_SYNC2 = 8'h05;
  localparam logic [7:0] TYPE_BLOB = 8'h41;
  localparam logic [7:0] TYPE_LINE = 8'h42;
  localparam logic [7:0] TYPE_TAG  = 8'h43;

  // Frame offsets of the fixed fields
  localparam int unsigned POS_HUNT  = 0;
  localparam int unsigned POS_SYNC1 = 1;
  localparam int unsigned POS_SYNC2 = 2;
  localparam int unsigned POS_TYPE  = 3;
  localparam int unsigned POS_LEN   = 4;

  // Kept payload window: frame offsets 5 to 15
  localparam int unsigned STORE_FIRST = 5;
  localparam int unsigned STORE_DEPTH = 11;

  // Report kinds
  localparam logic [2:0] KIND_OFFLINE = 3'd0;
  localparam logic [2:0] KIND_BLOB    = 3'd1;
  localparam logic [2:0] KIND_LINE    = 3'd2;
  localparam logic [2:0] KIND_TAG     = 3'd3;
  localparam logic [2:0] KIND_OTHER   = 3'd4;

  // Link modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_BLOB = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;
  localparam logic [1:0] MODE_TAG  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_CTR_Y  = 2'd1;
  localparam logic [1:0] REG_CTR_Z  = 2'd2;

  // Register reset values
  localparam logic [15:0] LIMIT_RST = 16'd1000;
  localparam logic [15:0] CTR_Y_RST = 16'd80;
  localparam logic [15:0] CTR_Z_RST = 16'd60;

endpackage

>>> hw/rtl/camera_frame_parser_with_timeout_unit.sv
// A result is written to the output register on the edge that accepts its input transaction.
// Throughput: one transaction per cycle; the parser and timer update in a single pass
// between the accepting edge and the output register. Input stalls only while a result
// waits in that register and out_ready is low.
// Reset (rst_n, synchronous, active low): parser hunts for sync, timer and offline cleared,
// mode none, registers at limit 1000 ms and tag centers 80 and 60; payload bytes undefined.
module camera_frame_parser_with_timeout_unit
  import cfpt_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 6);
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  // Configuration registers
  logic [15:0] limit_r;
  logic [15:0] ctr_y_r;
  logic [15:0] ctr_z_r;
  logic        cfg_wr;

  // Parser and link state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       store_r [STORE_DEPTH];
  logic [7:0]       store_eff [STORE_DEPTH];
  logic [15:0]      timer_r, timer_nxt;
  logic             offline_r, offline_nxt;
  logic [1:0]       mode_r, mode_nxt;

  // Output stage
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      res_valid;
  logic      in_acc;

  logic [POS_W-1:0] frame_end;
  logic [16:0]      timer_sum;
  logic [15:0]      tag_y;
  logic [15:0]      tag_z;
  logic [7:0]       b;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      ctr_y_r <= CTR_Y_RST;
      ctr_z_r <= CTR_Z_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LIMIT: limit_r <= pwdata[15:0];
        REG_CTR_Y: ctr_y_r <= pwdata[15:0];
        REG_CTR_Z: ctr_z_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[3:2])
      REG_LIMIT: prdata = {16'd0, limit_r};
      REG_CTR_Y: prdata = {16'd0, ctr_y_r};
      REG_CTR_Z: prdata = {16'd0, ctr_z_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign b         = in_data.byte_in;
  assign frame_end = POS_W'(len_r) + POS_W'(STORE_FIRST);

  // Payload view including the byte being taken now
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_eff[k] = (pos_r == POS_W'(STORE_FIRST + k)) ? b : store_r[k];
    end
  end

  assign tag_y     = ctr_y_r - {store_eff[1], store_eff[2]};
  assign tag_z     = ctr_z_r - {store_eff[3], store_eff[4]};
  assign timer_sum = {1'b0, timer_r} + 17'(in_data.elapsed_ms);

  // Parse a byte or advance the timer
  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    type_nxt    = type_r;
    timer_nxt   = timer_r;
    offline_nxt = offline_r;
    mode_nxt    = mode_r;
    res_valid   = 1'b0;
    res         = '0;
    if (in_data.mode == ITEM_TICK) begin
      if (timer_r < limit_r) begin
        timer_nxt = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
      end else begin
        mode_nxt = MODE_NONE;
        if (!offline_r) begin
          offline_nxt      = 1'b1;
          res_valid        = 1'b1;
          res.report_kind  = KIND_OFFLINE;
          res.current_mode = MODE_NONE;
          res.offline_flag = 1'b1;
        end
      end
    end else if (pos_r == POS_W'(POS_HUNT)) begin
      if (b == HDR_SYNC0) begin
        sum_nxt = b;
        pos_nxt = POS_W'(POS_SYNC1);
      end
    end else if (pos_r == POS_W'(POS_SYNC1) || pos_r == POS_W'(POS_SYNC2)) begin
      if (b == ((pos_r == POS_W'(POS_SYNC1)) ? HDR_SYNC1 : HDR_SYNC2)) begin
        sum_nxt = sum_r + b;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        pos_nxt = POS_W'(POS_HUNT);
      end
    end else if (pos_r == POS_W'(POS_TYPE)) begin
      type_nxt = b;
      sum_nxt  = sum_r + b;
      pos_nxt  = POS_W'(POS_LEN);
    end else if (pos_r == POS_W'(POS_LEN)) begin
      len_nxt = b[LEN_W-1:0];
      if (b <= 8'(MAX_PAYLOAD)) begin
        sum_nxt = sum_r + b;
        pos_nxt = POS_W'(STORE_FIRST);
      end else begin
        pos_nxt = POS_W'(POS_HUNT);
      end
    end else if (pos_r >= frame_end) begin
      pos_nxt = POS_W'(POS_HUNT);
      if (b == sum_r) begin
        // Decode a good frame
        res_valid   = 1'b1;
        timer_nxt   = 16'd0;
        offline_nxt = 1'b0;
        res.report_kind = KIND_OTHER;
        priority if (type_r == TYPE_BLOB) begin
          res.report_kind  = KIND_BLOB;
          res.status_byte  = store_eff[1];
          res.flag_byte    = store_eff[0];
          res.word_a       = {store_eff[2], store_eff[3]};
          res.word_b       = {store_eff[4], store_eff[5]};
          res.period_ms    = store_eff[6];
          mode_nxt         = MODE_BLOB;
        end else if (type_r == TYPE_LINE) begin
          res.report_kind  = KIND_LINE;
          res.status_byte  = store_eff[0];
          res.word_a       = {store_eff[1], store_eff[2]};
          res.word_b       = {store_eff[3], store_eff[4]};
          res.flag_byte    = store_eff[5];
          res.word_c       = {store_eff[6], store_eff[7]};
          res.word_d       = {store_eff[8], store_eff[9]};
          res.period_ms    = store_eff[10];
          mode_nxt         = MODE_LINE;
        end else if (type_r == TYPE_TAG) begin
          res.report_kind  = KIND_TAG;
          res.status_byte  = store_eff[0];
          if (store_eff[0] == 8'd0) begin
            res.word_a = tag_y;
            res.word_b = tag_z;
          end
          mode_nxt         = MODE_TAG;
        end else begin
        end
        res.current_mode = mode_nxt;
        res.offline_flag = 1'b0;
      end
    end else begin
      sum_nxt = sum_r + b;
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Hold parser and link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      len_r     <= '0;
      sum_r     <= '0;
      type_r    <= '0;
      timer_r   <= '0;
      offline_r <= 1'b0;
      mode_r    <= MODE_NONE;
    end else if (in_acc) begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      type_r    <= type_nxt;
      timer_r   <= timer_nxt;
      offline_r <= offline_nxt;
      mode_r    <= mode_nxt;
    end
  end

  // Store the kept payload window
  always_ff @(posedge clk) begin
    if (in_acc && in_data.mode == ITEM_BYTE) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        if (pos_r == POS_W'(STORE_FIRST + k)) begin
          store_r[k] <= b;
        end
      end
    end
  end

  // Load the output register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

  // Offline always leaves the mode cleared
  a_offline_mode: assert property (@(posedge clk) disable iff (!rst_n)
    offline_r |-> mode_r == MODE_NONE)
    else $error("offline with nonzero mode");

  // Payload position never passes the checksum byte
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r >= POS_W'(STORE_FIRST) |-> pos_r <= frame_end)
    else $error("parser position beyond frame end");

  // An offline report sets the offline state and fills the output register
  a_offline_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid && res.report_kind == KIND_OFFLINE |=> offline_r && out_valid_r)
    else $error("offline report without offline state");

  // Empty output stage never stalls the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule
